[sv/rrff_pkg.sv]
package rrff_pkg;

    localparam int ValW  = 64;
    localparam int CfgW  = 63;
    localparam int IdxW  = 2;
    localparam int FracW = 32;
    localparam int SumW  = ValW + 1;
    localparam int WideW = 130;

    localparam logic [CfgW-1:0]        ONE_CFG = 63'h0000_0001_0000_0000;
    localparam logic signed [ValW-1:0] ONE_Q   = 64'sh0000_0001_0000_0000;

    localparam logic [1:0] COMP_DENSITY = 2'd0;

    typedef enum logic [IdxW-1:0] {
        REG_LIGHT_SPEED         = 2'd0,
        REG_LIGHT_SPEED_SQUARED = 2'd1,
        REG_LIGHT_SPEED_INVERSE = 2'd2,
        REG_COMOVING_MODE       = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        UPWIND_LEFT  = 2'd0,
        UPWIND_RIGHT = 2'd1,
        UPWIND_BLEND = 2'd2
    } upwind_t;

    typedef struct packed {
        logic [1:0]             component;
        logic signed [ValW-1:0] left_state;
        logic signed [ValW-1:0] right_state;
        logic signed [ValW-1:0] left_flux_source;
        logic signed [ValW-1:0] right_flux_source;
        logic signed [ValW-1:0] left_velocity;
        logic signed [ValW-1:0] right_velocity;
        logic signed [ValW-1:0] face_velocity;
    } item_t;

    typedef struct packed {
        logic signed [ValW-1:0] face_flux;
        logic signed [ValW-1:0] face_state;
        upwind_t                upwind_case;
        logic                   negative_density;
    } result_t;

    typedef struct packed {
        logic [CfgW-1:0] light_speed;
        logic [CfgW-1:0] light_speed_squared;
        logic [CfgW-1:0] light_speed_inverse;
        logic            comoving_mode;
    } cfg_t;

    // Load enables of the partial product stage and the summing stage.
    typedef struct packed {
        logic pp;
        logic sum;
    } mul_en_t;

    // Clamp a wide signed value to the signed 64 bit range.
    function automatic logic signed [ValW-1:0] sat64(input logic signed [WideW-1:0] v);
        logic [WideW-ValW:0] top;
        top = v[WideW-1:ValW-1];
        if (top == '0 || top == '1)
        begin
            return v[ValW-1:0];
        end
        else if (v[WideW-1])
        begin
            return {1'b1, {(ValW-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(ValW-1){1'b1}}};
        end
    endfunction

endpackage

[sv/rrff_chan_if.sv]
interface rrff_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/rusanov_radiation_face_flux_top.sv]
// Seven-stage pipeline. One word is accepted per cycle while any stage is empty or
// the result channel is ready; every stage has its own valid bit and holds its
// contents only while the stage after it is full.
// The 64 by 64 bit products are formed from registered 32 by 32 bit partials.
// rst_n clears the valid bits at once and loads the registers with S = C2 = 1/S = 1.0.
module rusanov_radiation_face_flux_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [rrff_pkg::IdxW-1:0]  wr_index,
    input  logic [rrff_pkg::CfgW-1:0]  wr_data,
    rrff_chan_if.sink                  item,
    rrff_chan_if.source                result
);

    localparam int ValW  = rrff_pkg::ValW;
    localparam int SumW  = rrff_pkg::SumW;
    localparam int WideW = rrff_pkg::WideW;
    localparam int ProdW = 2 * ValW;
    localparam int AccW  = ProdW + 1;
    localparam int DampW = ValW + SumW;
    localparam int FracW = rrff_pkg::FracW;

    typedef struct packed {
        logic signed [ValW-1:0] sl;
        logic signed [ValW-1:0] sr;
        logic signed [SumW-1:0] ssum;
        logic                   neg;
        rrff_pkg::upwind_t      upcase;
    } side_t;

    rrff_pkg::cfg_t    cfg;
    rrff_pkg::item_t   it;
    rrff_pkg::mul_en_t en_cv;
    rrff_pkg::mul_en_t en_d;
    rrff_pkg::mul_en_t en_f;

    logic [7:1] en;
    logic [7:1] v_reg;
    logic [7:1] v_next;

    logic signed [ValW-1:0]  sl;
    logic signed [ValW-1:0]  sr;
    logic signed [ValW-1:0]  vf;
    logic signed [ValW-1:0]  s_pos;
    logic signed [ValW-1:0]  s_neg;
    logic signed [ValW-1:0]  c_sel;
    logic signed [ValW-1:0]  is_pos;
    side_t                   side_next;
    side_t                   side_reg [1:6];

    logic signed [ProdW-1:0] pc_l;
    logic signed [ProdW-1:0] pc_r;
    logic signed [ProdW-1:0] pv_l;
    logic signed [ProdW-1:0] pv_r;
    logic signed [SumW-1:0]  diff_reg;
    logic signed [AccW-1:0]  acc_l;
    logic signed [AccW-1:0]  acc_r;
    logic signed [ValW-1:0]  fl_next;
    logic signed [ValW-1:0]  fr_next;
    logic signed [ValW-1:0]  fl_reg [3:6];
    logic signed [ValW-1:0]  fr_reg [3:6];
    logic signed [SumW-1:0]  fsum_reg;
    logic signed [SumW-1:0]  fdif_reg;
    logic signed [DampW-1:0] damp;
    logic signed [DampW-1:0] fprod;
    logic signed [WideW-1:0] bflux_wide;
    logic signed [ValW-1:0]  bflux_reg5;
    logic signed [ValW-1:0]  bflux_reg6;
    logic signed [WideW-1:0] bstate_wide;
    logic signed [ValW-1:0]  bstate;
    rrff_pkg::result_t       result_next;
    rrff_pkg::result_t       result_reg;

    rrff_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb
    begin
        en[7] = !v_reg[7] || result.ready;
        for (int k = 6; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign v_next     = (v_reg & ~en) | ({v_reg[6:1], item.valid} & en);
    assign item.ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign en_cv.pp  = en[1];
    assign en_cv.sum = en[2];
    assign en_d.pp   = en[3];
    assign en_d.sum  = en[4];
    assign en_f.pp   = en[5];
    assign en_f.sum  = en[6];

    // Stage 1: upwind decision, state sums and partial products of the fluxes.
    assign it     = item.data;
    assign sl     = it.left_state;
    assign sr     = it.right_state;
    assign vf     = it.face_velocity;
    assign s_pos  = $signed({1'b0, cfg.light_speed});
    assign s_neg  = -s_pos;
    assign is_pos = $signed({1'b0, cfg.light_speed_inverse});
    assign c_sel  = (it.component == rrff_pkg::COMP_DENSITY) ? rrff_pkg::ONE_Q
                  : $signed({1'b0, cfg.light_speed_squared});

    always_comb
    begin
        side_next.sl   = sl;
        side_next.sr   = sr;
        side_next.ssum = SumW'(sl) + SumW'(sr);
        side_next.neg  = (it.component == rrff_pkg::COMP_DENSITY) && (sl[ValW-1] || sr[ValW-1]);
        if (vf <= s_neg)
        begin
            side_next.upcase = rrff_pkg::UPWIND_LEFT;
        end
        else if (vf >= s_pos)
        begin
            side_next.upcase = rrff_pkg::UPWIND_RIGHT;
        end
        else
        begin
            side_next.upcase = rrff_pkg::UPWIND_BLEND;
        end
    end

    rrff_mul #(.AW(ValW), .BW(ValW)) u_mul_cl (
        .clk (clk), .en (en_cv), .a (c_sel), .b (it.left_flux_source), .product (pc_l)
    );

    rrff_mul #(.AW(ValW), .BW(ValW)) u_mul_cr (
        .clk (clk), .en (en_cv), .a (c_sel), .b (it.right_flux_source), .product (pc_r)
    );

    rrff_mul #(.AW(ValW), .BW(ValW)) u_mul_vl (
        .clk (clk), .en (en_cv), .a (it.left_velocity), .b (sl), .product (pv_l)
    );

    rrff_mul #(.AW(ValW), .BW(ValW)) u_mul_vr (
        .clk (clk), .en (en_cv), .a (it.right_velocity), .b (sr), .product (pv_r)
    );

    // Stage 3: physical fluxes, with advection added in comoving mode.
    always_comb
    begin
        acc_l = AccW'(pc_l);
        acc_r = AccW'(pc_r);
        if (cfg.comoving_mode)
        begin
            acc_l = acc_l + AccW'(pv_l);
            acc_r = acc_r + AccW'(pv_r);
        end
    end

    assign fl_next = rrff_pkg::sat64(WideW'(acc_l >>> FracW));
    assign fr_next = rrff_pkg::sat64(WideW'(acc_r >>> FracW));

    // Damping term S * (right state - left state), partials in stage 3.
    rrff_mul #(.AW(ValW), .BW(SumW)) u_mul_damp (
        .clk (clk), .en (en_d), .a (s_pos), .b (diff_reg), .product (damp)
    );

    // Flux difference times 1/S, partials in stage 5.
    rrff_mul #(.AW(SumW), .BW(ValW)) u_mul_fdif (
        .clk (clk), .en (en_f), .a (fdif_reg), .b (is_pos), .product (fprod)
    );

    // The damping product is halved on its own before it meets the flux sum.
    assign bflux_wide  = ((WideW'(fsum_reg) <<< (FracW - 1)) - (WideW'(damp) >>> 1)) >>> FracW;
    assign bstate_wide = (WideW'(fprod) + (WideW'(side_reg[6].ssum) <<< FracW)) >>> (FracW + 1);
    assign bstate      = rrff_pkg::sat64(bstate_wide);

    always_comb
    begin
        result_next.upwind_case      = side_reg[6].upcase;
        result_next.negative_density = side_reg[6].neg;
        case (side_reg[6].upcase)
            rrff_pkg::UPWIND_LEFT:
            begin
                result_next.face_flux  = fl_reg[6];
                result_next.face_state = side_reg[6].sl;
            end
            rrff_pkg::UPWIND_RIGHT:
            begin
                result_next.face_flux  = fr_reg[6];
                result_next.face_state = side_reg[6].sr;
            end
            default:
            begin
                result_next.face_flux  = bflux_reg6;
                result_next.face_state = bstate;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            side_reg[1] <= side_next;
        end
        for (int k = 2; k <= 6; k++)
        begin
            if (en[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
        if (en[2])
        begin
            diff_reg <= SumW'(side_reg[1].sr) - SumW'(side_reg[1].sl);
        end
        if (en[3])
        begin
            fl_reg[3] <= fl_next;
            fr_reg[3] <= fr_next;
        end
        for (int k = 4; k <= 6; k++)
        begin
            if (en[k])
            begin
                fl_reg[k] <= fl_reg[k-1];
                fr_reg[k] <= fr_reg[k-1];
            end
        end
        if (en[4])
        begin
            fsum_reg <= SumW'(fl_reg[3]) + SumW'(fr_reg[3]);
            fdif_reg <= SumW'(fl_reg[3]) - SumW'(fr_reg[3]);
        end
        if (en[5])
        begin
            bflux_reg5 <= rrff_pkg::sat64(bflux_wide);
        end
        if (en[6])
        begin
            bflux_reg6 <= bflux_reg5;
        end
        if (en[7])
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid = v_reg[7];
    assign result.data  = result_reg;

endmodule

[sv/rrff_cfg.sv]
module rrff_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [rrff_pkg::IdxW-1:0]  wr_index,
    input  logic [rrff_pkg::CfgW-1:0]  wr_data,
    output rrff_pkg::cfg_t             cfg
);

    rrff_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.light_speed         <= rrff_pkg::ONE_CFG;
            cfg_reg.light_speed_squared <= rrff_pkg::ONE_CFG;
            cfg_reg.light_speed_inverse <= rrff_pkg::ONE_CFG;
            cfg_reg.comoving_mode       <= 1'b0;
        end
        else if (wr_en)
        begin
            case (rrff_pkg::reg_index_t'(wr_index))
                rrff_pkg::REG_LIGHT_SPEED:         cfg_reg.light_speed <= wr_data;
                rrff_pkg::REG_LIGHT_SPEED_SQUARED: cfg_reg.light_speed_squared <= wr_data;
                rrff_pkg::REG_LIGHT_SPEED_INVERSE: cfg_reg.light_speed_inverse <= wr_data;
                rrff_pkg::REG_COMOVING_MODE:       cfg_reg.comoving_mode <= wr_data[0];
                default:                           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/rrff_mul.sv]
// Two-stage signed multiplier: four partial products of roughly 32 by 32 bits
// are registered, then summed into the full product in the second stage.
module rrff_mul #(
    parameter int AW = 64,
    parameter int BW = 64
) (
    input  logic                     clk,
    input  rrff_pkg::mul_en_t        en,
    input  logic signed [AW-1:0]     a,
    input  logic signed [BW-1:0]     b,
    output logic signed [AW+BW-1:0]  product
);

    localparam int LhW = BW + 1;
    localparam int HlW = AW + 1;
    localparam int HhW = AW + BW - 64;
    localparam int PW  = AW + BW;

    logic [31:0]               al;
    logic [31:0]               bl;
    logic signed [AW-33:0]     ah;
    logic signed [BW-33:0]     bh;

    logic [63:0]               ll_next;
    logic signed [LhW-1:0]     lh_next;
    logic signed [HlW-1:0]     hl_next;
    logic signed [HhW-1:0]     hh_next;
    logic [63:0]               ll_reg;
    logic signed [LhW-1:0]     lh_reg;
    logic signed [HlW-1:0]     hl_reg;
    logic signed [HhW-1:0]     hh_reg;
    logic signed [PW-1:0]      product_next;
    logic signed [PW-1:0]      product_reg;

    assign al = a[31:0];
    assign bl = b[31:0];
    assign ah = a[AW-1:32];
    assign bh = b[BW-1:32];

    assign ll_next = 64'(al) * 64'(bl);
    assign lh_next = LhW'($signed({1'b0, al})) * LhW'(bh);
    assign hl_next = HlW'(ah) * HlW'($signed({1'b0, bl}));
    assign hh_next = HhW'(ah) * HhW'(bh);

    // The high-high and low-low products do not overlap, so they concatenate.
    assign product_next = $signed({hh_reg, ll_reg}) + (PW'(lh_reg) <<< 32)
                        + (PW'(hl_reg) <<< 32);

    always_ff @(posedge clk)
    begin
        if (en.pp)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
        end
        if (en.sum)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule
